FILE: rtl/telemetry_frame_decoder_defines.svh
// Assertion macros shared by the telemetry frame decoder checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TELEMETRY_FRAME_DECODER_DEFINES_SVH
`define TELEMETRY_FRAME_DECODER_DEFINES_SVH

// implication checked every clock, masked while reset is high
`define TFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while reset is high
`define TFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication that is also checked across reset
`define TFD_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/tfd_pkg.sv
// Types and constants for the telemetry frame decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tfd_pkg;

  localparam logic [7:0] MAGIC_0    = 8'hAA;
  localparam logic [7:0] MAGIC_1    = 8'hBB;
  localparam logic [4:0] HDR_LEN    = 5'd25;
  localparam logic [4:0] IMEI_FIRST = 5'd5;
  localparam logic [4:0] SEQ_FIRST  = 5'd20;
  localparam logic [4:0] COUNT_POS  = 5'd24;
  localparam logic [7:0] DIGIT_MAX  = 8'd9;

  // result kinds
  localparam logic [2:0] KIND_IMEI   = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_NAME   = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_FIELD  = 3'd4;

  // frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;

  // field type codes
  localparam logic [3:0] FT_NULL   = 4'd0;
  localparam logic [3:0] FT_BOOL   = 4'd1;
  localparam logic [3:0] FT_INT8   = 4'd2;
  localparam logic [3:0] FT_UINT8  = 4'd3;
  localparam logic [3:0] FT_INT16  = 4'd4;
  localparam logic [3:0] FT_UINT16 = 4'd5;
  localparam logic [3:0] FT_INT32  = 4'd6;
  localparam logic [3:0] FT_UINT32 = 4'd7;
  localparam logic [3:0] FT_FLOAT  = 4'd10;
  localparam logic [3:0] FT_DOUBLE = 4'd11;
  localparam logic [3:0] FT_STRING = 4'd12;
  localparam logic [3:0] FT_BLOB   = 4'd13;

  typedef enum logic [7:0] {
    PH_HDR   = 8'b0000_0001,
    PH_NLEN  = 8'b0000_0010,
    PH_NAME  = 8'b0000_0100,
    PH_TYPE  = 8'b0000_1000,
    PH_VAL   = 8'b0001_0000,
    PH_SLEN  = 8'b0010_0000,
    PH_SDATA = 8'b0100_0000,
    PH_DRAIN = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] field_value;
    logic [3:0]  field_type;
    logic [7:0]  char_byte;
    logic        imei_ok;
    logic [31:0] seq_number;
    logic [7:0]  ver_minor;
    logic [7:0]  ver_major;
    logic [7:0]  msg_type;
    logic        frame_end;
    logic [2:0]  kind;
  } result_t;

  // results produced by one accepted byte (zero, one or two)
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // value width in bytes for the fixed-size types; 1 for string and blob, else 0
  function automatic logic [7:0] size_of_type(input logic [3:0] code);
    logic [7:0] sz;
    case (code)
      FT_BOOL, FT_INT8, FT_UINT8:            sz = 8'd1;
      FT_INT16, FT_UINT16:                   sz = 8'd2;
      FT_INT32, FT_UINT32, FT_FLOAT:         sz = 8'd4;
      FT_DOUBLE:                             sz = 8'd8;
      FT_STRING, FT_BLOB:                    sz = 8'd1;
      default:                               sz = 8'd0;
    endcase
    return sz;
  endfunction

endpackage

FILE: rtl/tfd_parser.sv
// Frame parser: per-byte state update and result generation.
// Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output tfd_pkg::push_t push
);
  import tfd_pkg::*;

  phase_t      phase, phase_next;
  logic [4:0]  header_pos, header_pos_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  major_reg, major_reg_next;
  logic [7:0]  minor_reg, minor_reg_next;
  logic [31:0] seq_reg, seq_reg_next;
  logic        imei_good, imei_good_next;
  logic [7:0]  fields_left, fields_left_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [3:0]  cur_type, cur_type_next;
  logic [63:0] value_acc, value_acc_next;
  logic [2:0]  error_latch, error_latch_next;

  result_t     hdr_rec, fe_rec, fld_rec, chr_rec;
  logic        done_fire;
  logic [63:0] done_value;
  logic [7:0]  bl_dec, fl_dec;
  logic [2:0]  val_idx;
  logic [1:0]  seq_idx;
  logic [63:0] acc_new;
  logic        emit_chr;
  logic [2:0]  chr_kind;
  logic [2:0]  fe_status;

  assign bl_dec  = bytes_left - 8'd1;
  assign fl_dec  = fields_left - 8'd1;
  assign val_idx = 3'(size_of_type(cur_type) - bytes_left);
  assign seq_idx = 2'(header_pos - SEQ_FIRST);
  assign acc_new = value_acc | (64'(in_byte) << {val_idx, 3'b000});

  always_comb begin
    hdr_rec            = '0;
    hdr_rec.kind       = KIND_HEADER;
    hdr_rec.msg_type   = type_reg;
    hdr_rec.ver_major  = major_reg;
    hdr_rec.ver_minor  = minor_reg;
    hdr_rec.seq_number = seq_reg;
    hdr_rec.imei_ok    = imei_good;
  end

  always_comb begin
    phase_next       = phase;
    header_pos_next  = header_pos;
    type_reg_next    = type_reg;
    major_reg_next   = major_reg;
    minor_reg_next   = minor_reg;
    seq_reg_next     = seq_reg;
    imei_good_next   = imei_good;
    fields_left_next = fields_left;
    bytes_left_next  = bytes_left;
    cur_type_next    = cur_type;
    value_acc_next   = value_acc;
    error_latch_next = error_latch;
    done_fire        = 1'b0;
    done_value       = '0;
    emit_chr         = 1'b0;
    chr_kind         = KIND_IMEI;
    fe_status        = ST_OK;
    push             = '0;

    if (in_valid && in_last) begin
      if (header_pos < COUNT_POS) begin
        fe_status = ST_SHORT;
      end else if (error_latch != ST_OK) begin
        fe_status = error_latch;
      end else if (phase == PH_HDR) begin
        fe_status = ST_OK;
      end else if (phase == PH_NAME || phase == PH_TYPE || phase == PH_VAL ||
                   phase == PH_SLEN || phase == PH_SDATA) begin
        fe_status = ST_TRUNCATED;
      end
      // whole frame state returns to reset after the checksum byte
      phase_next       = PH_HDR;
      header_pos_next  = '0;
      type_reg_next    = '0;
      major_reg_next   = '0;
      minor_reg_next   = '0;
      seq_reg_next     = '0;
      imei_good_next   = 1'b1;
      fields_left_next = '0;
      bytes_left_next  = '0;
      cur_type_next    = '0;
      value_acc_next   = '0;
      error_latch_next = ST_OK;
    end else if (in_valid) begin
      if (header_pos < HDR_LEN) begin
        header_pos_next = header_pos + 5'd1;
      end
      case (phase)
        PH_HDR: begin
          if (header_pos == 5'd0 || header_pos == 5'd1) begin
            if (in_byte != ((header_pos == 5'd0) ? MAGIC_0 : MAGIC_1)) begin
              error_latch_next = ST_BAD_MAGIC;
              phase_next       = PH_DRAIN;
            end
          end else if (header_pos == 5'd2) begin
            type_reg_next = in_byte;
          end else if (header_pos == 5'd3) begin
            major_reg_next = in_byte;
          end else if (header_pos == 5'd4) begin
            minor_reg_next = in_byte;
          end else if (header_pos < SEQ_FIRST) begin
            if (in_byte > DIGIT_MAX) begin
              imei_good_next = 1'b0;
            end
            emit_chr = 1'b1;
            chr_kind = KIND_IMEI;
          end else if (header_pos < COUNT_POS) begin
            seq_reg_next = seq_reg | (32'(in_byte) << {seq_idx, 3'b000});
          end else begin
            fields_left_next = in_byte;
            phase_next       = (in_byte != 8'd0) ? PH_NLEN : PH_DRAIN;
          end
        end
        PH_NLEN: begin
          bytes_left_next = in_byte;
          phase_next      = (in_byte != 8'd0) ? PH_NAME : PH_TYPE;
        end
        PH_NAME: begin
          emit_chr        = 1'b1;
          chr_kind        = KIND_NAME;
          bytes_left_next = bl_dec;
          if (bl_dec == 8'd0) begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (in_byte > 8'(FT_BLOB) || in_byte == 8'd8 || in_byte == 8'd9) begin
            error_latch_next = ST_UNKNOWN;
            phase_next       = PH_DRAIN;
          end else begin
            cur_type_next  = in_byte[3:0];
            value_acc_next = '0;
            if (in_byte[3:0] == FT_NULL) begin
              done_fire = 1'b1;
            end else if (in_byte[3:0] == FT_STRING || in_byte[3:0] == FT_BLOB) begin
              phase_next = PH_SLEN;
            end else begin
              bytes_left_next = size_of_type(in_byte[3:0]);
              phase_next      = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          value_acc_next  = acc_new;
          bytes_left_next = bl_dec;
          if (bl_dec == 8'd0) begin
            done_fire  = 1'b1;
            done_value = (cur_type == FT_BOOL) ? 64'(acc_new != '0) : acc_new;
          end
        end
        PH_SLEN: begin
          value_acc_next  = 64'(in_byte);
          bytes_left_next = in_byte;
          if (in_byte == 8'd0) begin
            done_fire = 1'b1;
          end else begin
            phase_next = PH_SDATA;
          end
        end
        PH_SDATA: begin
          emit_chr        = 1'b1;
          chr_kind        = KIND_STRING;
          bytes_left_next = bl_dec;
          if (bl_dec == 8'd0) begin
            done_fire  = 1'b1;
            done_value = value_acc;
          end
        end
        default: begin
        end
      endcase
      if (done_fire) begin
        fields_left_next = fl_dec;
        phase_next       = (fl_dec != 8'd0) ? PH_NLEN : PH_DRAIN;
      end
    end

    fe_rec           = '0;
    fe_rec.frame_end = 1'b1;
    fe_rec.status    = fe_status;

    fld_rec             = '0;
    fld_rec.kind        = KIND_FIELD;
    fld_rec.field_type  = cur_type_next;
    fld_rec.field_value = done_value;

    chr_rec           = '0;
    chr_rec.kind      = chr_kind;
    chr_rec.char_byte = in_byte;

    if (in_valid && in_last) begin
      if (header_pos >= COUNT_POS && error_latch == ST_OK && phase == PH_HDR) begin
        push.count  = 2'd2;
        push.first  = hdr_rec;
        push.second = fe_rec;
      end else begin
        push.count = 2'd1;
        push.first = fe_rec;
      end
    end else if (in_valid && phase == PH_HDR && header_pos == COUNT_POS) begin
      push.count = 2'd1;
      push.first = hdr_rec;
    end else if (in_valid && done_fire && emit_chr) begin
      // last string/blob byte: the char, then the completed field
      push.count  = 2'd2;
      push.first  = chr_rec;
      push.second = fld_rec;
    end else if (in_valid && done_fire) begin
      push.count = 2'd1;
      push.first = fld_rec;
    end else if (in_valid && emit_chr) begin
      push.count = 2'd1;
      push.first = chr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR;
      header_pos  <= '0;
      type_reg    <= '0;
      major_reg   <= '0;
      minor_reg   <= '0;
      seq_reg     <= '0;
      imei_good   <= 1'b1;
      fields_left <= '0;
      bytes_left  <= '0;
      cur_type    <= '0;
      value_acc   <= '0;
      error_latch <= ST_OK;
    end else begin
      phase       <= phase_next;
      header_pos  <= header_pos_next;
      type_reg    <= type_reg_next;
      major_reg   <= major_reg_next;
      minor_reg   <= minor_reg_next;
      seq_reg     <= seq_reg_next;
      imei_good   <= imei_good_next;
      fields_left <= fields_left_next;
      bytes_left  <= bytes_left_next;
      cur_type    <= cur_type_next;
      value_acc   <= value_acc_next;
      error_latch <= error_latch_next;
    end
  end

endmodule

FILE: rtl/tfd_outq.sv
// Four-entry result queue between the parser and the output channel.
// Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_outq (
  input  logic             clk,
  input  logic             rst,
  input  tfd_pkg::push_t   push,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output tfd_pkg::result_t out_data
);
  import tfd_pkg::*;

  result_t    mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  // room for the worst case of two results per byte
  assign in_ready   = (count <= 3'd2);
  assign out_valid  = (count != 3'd0);
  assign out_data   = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign count_next = count + 3'(push.count) - 3'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count_next;
    end
  end

endmodule

FILE: rtl/telemetry_frame_decoder.sv
// Telemetry frame decoder top level: byte stream in, decoded records out.
// Depends on tfd_pkg, tfd_parser and tfd_outq.
`timescale 1ns / 1ps
//
// Input: one frame byte per transaction on s_axis, s_axis_tlast on the final
// (checksum) byte. Output: one record per transaction on m_axis; tuser gives
// the kind (IMEI digit, header, name char, string/blob char, field done),
// tlast marks the frame-end record whose status field closes the frame.
// Each byte updates the parser state in the cycle it is accepted, and its
// records are written into a four-entry queue that drives m_axis. Bytes
// are taken one per cycle while s_axis_tready is high; a byte gives at most
// two records (header plus frame end when the count byte is also the last,
// or the last string/blob char plus its field done). s_axis_tready is low
// while the queue holds more than two records, so a stalled receiver stops
// input before the queue can overflow and no record is lost.
// Records leave at one per cycle while m_axis_tready is high. Synchronous
// reset returns the parser to the start of a frame and empties the queue;
// after each frame-end record the parser is back in the same state.
//
module telemetry_frame_decoder (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] msg_type, [15:8] ver_major, [23:16] ver_minor, [55:24] seq_number,
  // [56] imei_ok, [64:57] char_byte, [68:65] field_type,
  // [132:69] field_value, [135:133] status
  output logic [135:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // [2:0] kind
  output logic         m_axis_tlast
);
  import tfd_pkg::*;

  push_t   push;
  result_t res;
  logic    take;

  assign take = s_axis_tvalid && s_axis_tready;

  tfd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (take),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .push     (push)
  );

  tfd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.frame_end;
  assign m_axis_tdata = {res.status, res.field_value, res.field_type, res.char_byte,
                         res.imei_ok, res.seq_number, res.ver_minor, res.ver_major,
                         res.msg_type};

endmodule

FILE: rtl/tfd_checker.sv
// Port-level checks for the telemetry frame decoder, bound to the top level.
// Depends on tfd_pkg and telemetry_frame_decoder_defines.svh.
`timescale 1ns / 1ps
`include "telemetry_frame_decoder_defines.svh"

module tfd_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [2:0]   m_axis_tuser,
  input logic         m_axis_tlast,
  input logic [135:0] m_axis_tdata
);
  import tfd_pkg::*;

  // queue is empty right after reset
  `TFD_ASSERT_ALWAYS(a_empty_after_rst, clk, $past(rst), !m_axis_tvalid, "record after reset")

  // frame-end records carry no kind of their own
  `TFD_ASSERT_IMP(a_end_kind, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_IMEI, "frame end with kind set")

  // only defined kinds leave the block
  `TFD_ASSERT_IMP(a_kind_range, clk, rst, m_axis_tvalid, m_axis_tuser <= KIND_FIELD, "undefined kind")

  // a stalled record stays offered
  `TFD_ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "record dropped under stall")

endmodule

bind telemetry_frame_decoder tfd_checker u_tfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tdata  (m_axis_tdata)
);
